// ===== hdl/pwmtc_pkg.sv =====
// Shared widths, constants and microcode for the PWM timing calculator.
// Used by pwmtc_divider and pwm_timing_calculator_top; depends on nothing.
package pwmtc_pkg;

    localparam int COUNTER_BITS = 16;

    localparam int CLK_W   = 32;
    localparam int FREQ_W  = 32;
    localparam int DUTY_W  = 16;
    localparam int PSC_W   = 16;
    localparam int PER_W   = 16;
    localparam int PULSE_W = 17;

    // Capped duty (0..1000) and tick count (1..2^COUNTER_BITS)
    localparam int DUTYC_W = 10;
    localparam int TICK_W  = COUNTER_BITS + 1;

    // Divider numerator: the clock, wide enough to compare against the tick range
    localparam int NUM_W = (TICK_W + DUTYC_W > CLK_W) ? TICK_W + DUTYC_W : CLK_W;
    // Divider denominator: freq * (range + 1), or (psc + 1) * freq
    localparam int DEN_A_W = FREQ_W + COUNTER_BITS + 1;
    localparam int DEN_B_W = FREQ_W + PSC_W + 1;
    localparam int DEN_W   = (DEN_A_W > DEN_B_W) ? DEN_A_W : DEN_B_W;
    localparam int CNT_W   = $clog2(NUM_W + 1);

    localparam logic [CLK_W-1:0]   DEFAULT_CLOCK_HZ = CLK_W'(1000000);
    localparam logic [PSC_W-1:0]   PSC_MAX          = {PSC_W{1'b1}};
    localparam logic [DUTYC_W-1:0] DUTY_MAX         = DUTYC_W'(1000);
    localparam logic [NUM_W-1:0]   TICK_RANGE       = NUM_W'(1) << COUNTER_BITS;

    // Pulse: ticks * duty divided by 1000 through a rounded-up reciprocal.
    // With a shift of PROD_W + DUTYC_W the rounding error stays below one unit.
    localparam int PROD_W      = TICK_W + DUTYC_W;
    localparam int RECIP_SHIFT = PROD_W + DUTYC_W;
    localparam int RECIP_W     = RECIP_SHIFT - 9;
    localparam logic [RECIP_W-1:0] DUTY_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DUTY_MAX) - 64'd1) / 64'(DUTY_MAX));

    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_LOAD_PSC,
        OP_WAIT_DIV,
        OP_SET_PSC,
        OP_LOAD_TICKS,
        OP_SET_TICKS,
        OP_LOAD_PULSE,
        OP_SET_PULSE,
        OP_EMIT
    } op_t;

    // Jump to target when the condition holds, else advance
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DIV_BUSY,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            PC_W'(0):  w = '{OP_ACCEPT,     COND_NO_INPUT, PC_W'(0)};
            PC_W'(1):  w = '{OP_LOAD_PSC,   COND_NEVER,    PC_W'(0)};
            PC_W'(2):  w = '{OP_WAIT_DIV,   COND_DIV_BUSY, PC_W'(2)};
            PC_W'(3):  w = '{OP_SET_PSC,    COND_NEVER,    PC_W'(0)};
            PC_W'(4):  w = '{OP_LOAD_TICKS, COND_NEVER,    PC_W'(0)};
            PC_W'(5):  w = '{OP_WAIT_DIV,   COND_DIV_BUSY, PC_W'(5)};
            PC_W'(6):  w = '{OP_SET_TICKS,  COND_NEVER,    PC_W'(0)};
            PC_W'(7):  w = '{OP_LOAD_PULSE, COND_NEVER,    PC_W'(0)};
            PC_W'(8):  w = '{OP_SET_PULSE,  COND_NEVER,    PC_W'(0)};
            PC_W'(9):  w = '{OP_EMIT,       COND_OUT_FULL, PC_W'(9)};
            PC_W'(10): w = '{OP_NOP,        COND_ALWAYS,   PC_W'(0)};
            default:   w = '{OP_NOP,        COND_ALWAYS,   PC_W'(0)};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/pwmtc_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pwmtc_pkg for operand widths.
module pwmtc_divider import pwmtc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic [NUM_W-1:0] quotient
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign take  = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits DEN_W bits
            rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], take};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/pwm_timing_calculator_top.sv =====
// PWM timing calculator: prescaler, period and compare value for an up-counting timer.
// Depends on pwmtc_pkg (widths, microcode) and pwmtc_divider.
//
// Usage:
//   cfg_*  : one-register write channel holding the timer input clock in Hz
//            (zero means 1 MHz). Always ready. Write only while the block is idle.
//   s_*    : request transfer: wanted frequency in Hz and duty in permille.
//   m_*    : result transfer: prescaler, auto-reload period and compare pulse.
// A microcoded sequencer steps through a small control ROM and drives one shared
// serial divider through two divisions: clock / (freq * (range + 1)) for the
// prescaler and clock / ((psc + 1) * freq) for the tick count. The pulse,
// ticks * duty / 1000, takes one product step and one reciprocal-multiply step.
// Each division iterates over the NUM_W (32) dividend bits while its wait step holds the
// sequencer; requests are handled one at a time, and the next request is taken only
// after the result is loaded into the output register.
// The result sits in an output register: if the receiver stalls, the sequencer
// holds at its emit step until the register frees, then returns to accept.
// Reset (aresetn low, synchronous) returns the sequencer to its accept step, drops
// any pending result and restores the input clock register to 1 MHz.
module pwm_timing_calculator_top import pwmtc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CLK_W-1:0]    cfg_input_clock_hz,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FREQ_W-1:0]   s_target_frequency_hz,
    input  logic [DUTY_W-1:0]   s_duty_permille,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [PSC_W-1:0]    m_prescaler,
    output logic [PER_W-1:0]    m_period,
    output logic [PULSE_W-1:0]  m_pulse
);

    // configuration register
    logic [CLK_W-1:0] clock_reg, clock_next;

    // sequencer
    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          uc;
    logic            cond_true;

    // datapath
    logic [CLK_W-1:0]   clk_eff_reg, clk_eff_next;
    logic [FREQ_W-1:0]  freq_reg, freq_next;
    logic [DUTYC_W-1:0] duty_reg, duty_next;
    logic [PSC_W-1:0]   psc_reg, psc_next;
    logic [TICK_W-1:0]  ticks_reg, ticks_next;
    logic [PSC_W:0]     psc_inc;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [PULSE_W-1:0] pulse_reg, pulse_next;
    logic [PROD_W+RECIP_W-1:0] recip_prod;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [PSC_W-1:0]   m_prescaler_reg, m_prescaler_next;
    logic [PER_W-1:0]   m_period_reg, m_period_next;
    logic [PULSE_W-1:0] m_pulse_reg, m_pulse_next;
    logic               out_blocked;

    // divider
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_busy;
    logic [NUM_W-1:0] div_quo;

    pwmtc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign cfg_ready  = 1'b1;
    assign clock_next = (cfg_valid && cfg_ready) ? cfg_input_clock_hz : clock_reg;

    assign uc          = ucode_rom(pc_reg);
    assign out_blocked = m_valid_reg && !m_ready;
    assign s_ready     = (uc.op == OP_ACCEPT);
    assign psc_inc     = {1'b0, psc_reg} + (PSC_W + 1)'(1);

    // product of ticks * duty with the rounded-up reciprocal of 1000
    assign recip_prod  = (PROD_W + RECIP_W)'(prod_reg) * (PROD_W + RECIP_W)'(DUTY_RECIP);

    // condition select: jump on true, advance otherwise
    always_comb begin
        case (uc.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_NO_INPUT: cond_true = !s_valid;
            COND_DIV_BUSY: cond_true = div_busy;
            COND_OUT_FULL: cond_true = out_blocked;
            default:       cond_true = 1'b1;
        endcase
        pc_next = cond_true ? uc.target : pc_reg + PC_W'(1);
    end

    // datapath driven by the current control word
    always_comb begin
        clk_eff_next     = clk_eff_reg;
        freq_next        = freq_reg;
        duty_next        = duty_reg;
        psc_next         = psc_reg;
        ticks_next       = ticks_reg;
        prod_next        = prod_reg;
        pulse_next       = pulse_reg;
        div_start        = 1'b0;
        div_num          = NUM_W'(clk_eff_reg);
        div_den          = '0;
        m_valid_next     = m_valid_reg && !m_ready;
        m_prescaler_next = m_prescaler_reg;
        m_period_next    = m_period_reg;
        m_pulse_next     = m_pulse_reg;

        case (uc.op)
            OP_ACCEPT: begin
                // latch the request with zero clock, zero frequency and duty cap applied
                if (s_valid) begin
                    clk_eff_next = (clock_reg == '0) ? DEFAULT_CLOCK_HZ : clock_reg;
                    freq_next    = (s_target_frequency_hz == '0) ? FREQ_W'(1)
                                                                 : s_target_frequency_hz;
                    duty_next    = (s_duty_permille > DUTY_W'(DUTY_MAX)) ? DUTY_MAX
                                   : s_duty_permille[DUTYC_W-1:0];
                end
            end
            OP_LOAD_PSC: begin
                // freq * (range + 1) as shift and add
                div_start = 1'b1;
                div_den   = (DEN_W'(freq_reg) << COUNTER_BITS) + DEN_W'(freq_reg);
            end
            OP_SET_PSC: begin
                psc_next = (div_quo > NUM_W'(PSC_MAX)) ? PSC_MAX : div_quo[PSC_W-1:0];
            end
            OP_LOAD_TICKS: begin
                div_start = 1'b1;
                div_den   = DEN_W'(psc_inc) * DEN_W'(freq_reg);
            end
            OP_SET_TICKS: begin
                // force at least one tick, cap at the counter range
                if (div_quo == '0) begin
                    ticks_next = TICK_W'(1);
                end else if (div_quo > TICK_RANGE) begin
                    ticks_next = TICK_RANGE[TICK_W-1:0];
                end else begin
                    ticks_next = div_quo[TICK_W-1:0];
                end
            end
            OP_LOAD_PULSE: begin
                prod_next = PROD_W'(ticks_reg) * PROD_W'(duty_reg);
            end
            OP_SET_PULSE: begin
                // drop the reciprocal fraction bits to get the quotient by 1000
                pulse_next = recip_prod[RECIP_SHIFT +: PULSE_W];
            end
            OP_EMIT: begin
                // load the result register once it is free
                if (!out_blocked) begin
                    m_valid_next     = 1'b1;
                    m_prescaler_next = psc_reg;
                    m_period_next    = PER_W'(ticks_reg - TICK_W'(1));
                    m_pulse_next     = pulse_reg;
                end
            end
            OP_WAIT_DIV: begin
                // hold while the divider iterates
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg   <= DEFAULT_CLOCK_HZ;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            clock_reg   <= clock_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
        clk_eff_reg     <= clk_eff_next;
        freq_reg        <= freq_next;
        duty_reg        <= duty_next;
        psc_reg         <= psc_next;
        ticks_reg       <= ticks_next;
        prod_reg        <= prod_next;
        pulse_reg       <= pulse_next;
        m_prescaler_reg <= m_prescaler_next;
        m_period_reg    <= m_period_next;
        m_pulse_reg     <= m_pulse_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_prescaler = m_prescaler_reg;
    assign m_period    = m_period_reg;
    assign m_pulse     = m_pulse_reg;

endmodule
